FILE: sv/planar_tile_to_chunky_pixels_core_assert.svh
// ----------------------------------------------------------------------------
// planar tile decoder assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PLANAR_TILE_TO_CHUNKY_PIXELS_CORE_ASSERT_SVH
`define PLANAR_TILE_TO_CHUNKY_PIXELS_CORE_ASSERT_SVH

`ifndef SYNTH

// implication checked every cycle out of reset
`define PTCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition checked every cycle out of reset
`define PTCP_ASSERT_COND(lbl, cond, msg) \
  `PTCP_ASSERT(lbl, (cond), msg)

`else

`define PTCP_ASSERT(lbl, prop, msg)
`define PTCP_ASSERT_COND(lbl, cond, msg)

`endif

`endif

FILE: sv/ptcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_pkg
// shared types, widths and helpers of the planar tile decoder
// ----------------------------------------------------------------------------
package ptcp_pkg;

  localparam int MAX_TILES_WIDE = 64;
  localparam int MAX_TILES_HIGH = 64;

  localparam int PLANE_W   = 8;
  localparam int PIX_W     = 4;
  localparam int NUM_PIX   = 8;
  localparam int RIT_W     = 3;
  localparam int ADDR_W    = 32;
  localparam int STRIDE_W  = 16;
  localparam int CFG_SIZE_W = 7;
  localparam int OFFSET_W  = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int COL_W    = (MAX_TILES_WIDE > 1) ? $clog2(MAX_TILES_WIDE) : 1;
  localparam int ROW_W    = (MAX_TILES_HIGH > 1) ? $clog2(MAX_TILES_HIGH) : 1;
  localparam int WSIZE_W  = $clog2(MAX_TILES_WIDE + 1);
  localparam int HSIZE_W  = $clog2(MAX_TILES_HIGH + 1);

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS   = 3'd0,
    REG_ROW_STRIDE     = 3'd1,
    REG_WIDTH_TILES    = 3'd2,
    REG_HEIGHT_TILES   = 3'd3,
    REG_TWO_PLANE_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base_address;
    logic [STRIDE_W-1:0] row_stride;
    logic [WSIZE_W-1:0]  width_eff;
    logic [HSIZE_W-1:0]  height_eff;
    logic                two_plane;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] tile_column;
    logic [ROW_W-1:0] tile_row;
    logic [RIT_W-1:0] row_in_tile;
    logic             last_row;
  } pos_t;

  typedef struct packed {
    logic [NUM_PIX-1:0][PIX_W-1:0] pixels;
    logic [ADDR_W-1:0]             source_address;
    logic [OFFSET_W-1:0]           pixel_offset;
    logic                          last_row;
  } res_t;

  // zero acts as one, oversize saturates
  function automatic logic [WSIZE_W-1:0] eff_width(input logic [CFG_SIZE_W-1:0] v);
    logic [WSIZE_W-1:0] r;
    if (v == '0) r = WSIZE_W'(1);
    else if (32'(v) > MAX_TILES_WIDE) r = WSIZE_W'(MAX_TILES_WIDE);
    else r = WSIZE_W'(v);
    return r;
  endfunction

  function automatic logic [HSIZE_W-1:0] eff_height(input logic [CFG_SIZE_W-1:0] v);
    logic [HSIZE_W-1:0] r;
    if (v == '0) r = HSIZE_W'(1);
    else if (32'(v) > MAX_TILES_HIGH) r = HSIZE_W'(MAX_TILES_HIGH);
    else r = HSIZE_W'(v);
    return r;
  endfunction

endpackage

FILE: sv/ptcp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_cfg
// configuration registers, sizes kept in clamped form
// ----------------------------------------------------------------------------
module ptcp_cfg import ptcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_ADDRESS:   cfg_nxt.base_address = cfg_data[ADDR_W-1:0];
        REG_ROW_STRIDE:     cfg_nxt.row_stride   = cfg_data[STRIDE_W-1:0];
        REG_WIDTH_TILES:    cfg_nxt.width_eff    = eff_width(cfg_data[CFG_SIZE_W-1:0]);
        REG_HEIGHT_TILES:   cfg_nxt.height_eff   = eff_height(cfg_data[CFG_SIZE_W-1:0]);
        REG_TWO_PLANE_MODE: cfg_nxt.two_plane    = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= '0;
      cfg_r.row_stride   <= ROW_STRIDE_RST;
      cfg_r.width_eff    <= WSIZE_W'(1);
      cfg_r.height_eff   <= HSIZE_W'(1);
      cfg_r.two_plane    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/ptcp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_seq
// tile column, tile row and row-in-tile counters of the sweep
// ----------------------------------------------------------------------------
module ptcp_seq import ptcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  cfg_t cfg,
  output pos_t pos
);

`include "planar_tile_to_chunky_pixels_core_assert.svh"

  logic [COL_W-1:0] tile_column_r, tile_column_nxt;
  logic [ROW_W-1:0] tile_row_r, tile_row_nxt;
  logic [RIT_W-1:0] row_in_tile_r, row_in_tile_nxt;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_end, row_end, rit_end;

  assign col_inc = {1'b0, tile_column_r} + (COL_W+1)'(1);
  assign row_inc = {1'b0, tile_row_r} + (ROW_W+1)'(1);
  assign col_end = 32'(col_inc) >= 32'(cfg.width_eff);
  assign row_end = 32'(row_inc) >= 32'(cfg.height_eff);
  assign rit_end = row_in_tile_r == {RIT_W{1'b1}};

  assign pos.tile_column = tile_column_r;
  assign pos.tile_row    = tile_row_r;
  assign pos.row_in_tile = row_in_tile_r;
  assign pos.last_row    = col_end && row_end && rit_end;

  always_comb begin
    tile_column_nxt = tile_column_r;
    tile_row_nxt    = tile_row_r;
    row_in_tile_nxt = row_in_tile_r;
    if (adv) begin
      row_in_tile_nxt = row_in_tile_r + RIT_W'(1);
      if (rit_end) begin
        if (col_end) begin
          tile_column_nxt = '0;
          tile_row_nxt    = row_end ? '0 : row_inc[ROW_W-1:0];
        end else begin
          tile_column_nxt = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_column_r <= '0;
      tile_row_r    <= '0;
      row_in_tile_r <= '0;
    end else begin
      tile_column_r <= tile_column_nxt;
      tile_row_r    <= tile_row_nxt;
      row_in_tile_r <= row_in_tile_nxt;
    end
  end

  `PTCP_ASSERT(a_rit_step, adv |=> row_in_tile_r == RIT_W'($past(row_in_tile_r) + 1'b1), "row in tile did not step")
  `PTCP_ASSERT(a_col_hold, (!adv || !rit_end) |=> $stable(tile_column_r), "tile column moved mid tile")
  `PTCP_ASSERT(a_wrap, (adv && pos.last_row) |=> (tile_column_r == '0 && tile_row_r == '0 && row_in_tile_r == '0), "sweep did not restart after last row")

endmodule

FILE: sv/ptcp_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_dec
// plane bits to chunky pixels, bitmap offset and source address of a row
// ----------------------------------------------------------------------------
module ptcp_dec import ptcp_pkg::*; (
  input  logic [PLANE_W-1:0] plane0,
  input  logic [PLANE_W-1:0] plane1,
  input  logic [PLANE_W-1:0] plane2,
  input  logic [PLANE_W-1:0] plane3,
  input  pos_t               pos,
  input  cfg_t               cfg,
  output res_t               res
);

  localparam int LINE_W = ROW_W + RIT_W;
  localparam int PROD_W = LINE_W + WSIZE_W;
  localparam int SUM_W  = PROD_W + 4;

  logic [PLANE_W-1:0]            p2, p3;
  logic [NUM_PIX-1:0][PIX_W-1:0] pix;
  logic [LINE_W-1:0]             line;
  logic [PROD_W-1:0]             line_prod;
  logic [SUM_W-1:0]              offset_sum;
  logic [STRIDE_W+ROW_W-1:0]     stride_prod;
  logic [COL_W+5-1:0]            col_bytes;

  assign p2 = cfg.two_plane ? '0 : plane2;
  assign p3 = cfg.two_plane ? '0 : plane3;

  // leftmost pixel from bit 7, plane p gives index bit p
  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      pix[i] = {p3[NUM_PIX-1-i], p2[NUM_PIX-1-i], plane1[NUM_PIX-1-i], plane0[NUM_PIX-1-i]};
    end
  end

  assign res.pixels = pix;

  // (8*row + rit) * 8*w + 8*col
  assign line       = {pos.tile_row, pos.row_in_tile};
  assign line_prod  = PROD_W'(line) * PROD_W'(cfg.width_eff);
  assign offset_sum = {1'b0, line_prod, 3'b000} + SUM_W'({pos.tile_column, 3'b000});
  assign res.pixel_offset = offset_sum[OFFSET_W-1:0];

  assign stride_prod = (STRIDE_W+ROW_W)'(cfg.row_stride) * (STRIDE_W+ROW_W)'(pos.tile_row);
  assign col_bytes   = cfg.two_plane ? {1'b0, pos.tile_column, 4'b0000}
                                     : {pos.tile_column, 5'b00000};

  assign res.source_address = cfg.base_address
                            + ADDR_W'(stride_prod)
                            + ADDR_W'(col_bytes)
                            + ADDR_W'({pos.row_in_tile, 1'b0});

  assign res.last_row = pos.last_row;

endmodule

FILE: sv/planar_tile_to_chunky_pixels_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_to_chunky_pixels_core
// decodes 8x8 planar tile rows into eight 4-bit chunky pixel indices
// ----------------------------------------------------------------------------
//
// channel  | dir | fields
// ---------+-----+-----------------------------------------------------------
// in_      | in  | tdata: plane0..plane3 bytes
// out_     | out | tdata: offset, address, pixels a..h; tlast: last row
// cfg_     | in  | index 0..4: base, stride, width, height, two-plane
//
// one item per cycle while out_ is not stalled; an accepted item passes to out_
// through the input register, then the result register behind the decode logic
// the sweep counters advance at input accept, so each item is tagged in order
// rst_n clears counters and valid bits and sets the config registers to their defaults
// a stalled out_ holds its result; in_ still takes one more item into the
// input register, then in_tready drops until the result register drains
//
module planar_tile_to_chunky_pixels_core import ptcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [87:0]           out_tdata,  // pixel_offset, source_address, pixel_a..pixel_h, pad
  output logic                  out_tlast,  // last_row
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "planar_tile_to_chunky_pixels_core_assert.svh"

  localparam int PAD_W = 88 - (OFFSET_W + ADDR_W + NUM_PIX*PIX_W);

  cfg_t cfg;
  pos_t pos;
  res_t res;

  logic in_acc, s2_adv;

  // input register stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic [4*PLANE_W-1:0]  s1_data_r;
  pos_t                  s1_pos_r;

  // result register stage
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign s2_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_adv;
  assign in_acc    = in_tvalid && in_tready;

  ptcp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptcp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (in_acc),
    .cfg   (cfg),
    .pos   (pos)
  );

  ptcp_dec u_dec (
    .plane0 (s1_data_r[PLANE_W-1:0]),
    .plane1 (s1_data_r[2*PLANE_W-1:PLANE_W]),
    .plane2 (s1_data_r[3*PLANE_W-1:2*PLANE_W]),
    .plane3 (s1_data_r[4*PLANE_W-1:3*PLANE_W]),
    .pos    (s1_pos_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s2_adv) s1_valid_nxt = 1'b0;
  end

  assign out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_pos_r  <= pos;
    end
    if (s2_adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last_row;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.pixels, out_res_r.source_address,
                       out_res_r.pixel_offset};

  // a full input register only takes a new item while it hands its own on
  `PTCP_ASSERT(a_no_overwrite, (in_acc && s1_valid_r) |-> s2_adv, "input register overwritten")
  // an item that moves on always shows up as a result next cycle
  `PTCP_ASSERT(a_s1_to_out, (s2_adv && s1_valid_r) |=> out_tvalid, "item lost between stages")
  // an item held behind a stalled output stays in the input register
  `PTCP_ASSERT(a_s1_hold, (s1_valid_r && !s2_adv) |=> (s1_valid_r && $stable(s1_data_r)), "held item dropped")

endmodule

FILE: tb/planar_tile_to_chunky_pixels_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_to_chunky_pixels_core_tb
// drives tile rows and register writes into the planar tile decoder and checks
// every decoded row (offset, address, eight pixels, last-row flag) against a
// row predictor kept in step with the block's sweep counters
// ----------------------------------------------------------------------------
module planar_tile_to_chunky_pixels_core_tb;
  import ptcp_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;
  localparam int NUM_PHASES   = 6;

  // indexes past the register list, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [OFFSET_W-1:0]           offset;
    logic [ADDR_W-1:0]             addr;
    logic [NUM_PIX-1:0][PIX_W-1:0] pix;   // pix[0] is the leftmost pixel
    logic                          last;
  } row_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;   // plane0, plane1, plane2, plane3 bytes
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [87:0]           out_tdata;         // pixel_offset, source_address, pixel_a..h
  logic                  out_tlast;         // last_row
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor copy of the registers and the sweep position
  logic [ADDR_W-1:0]     m_base;
  logic [STRIDE_W-1:0]   m_stride;
  logic [CFG_SIZE_W-1:0] m_width;
  logic [CFG_SIZE_W-1:0] m_height;
  logic                  m_two_plane;
  logic [5:0]            m_col;
  logic [5:0]            m_row;
  logic [2:0]            m_rit;

  row_result_t pending_rows[$];
  int          rows_sent    = 0;
  int          rows_checked = 0;
  int          cfg_writes   = 0;
  int          mismatches   = 0;
  int          cycles       = 0;
  bit          idle_on      = 1'b1;

  planar_tile_to_chunky_pixels_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // result side back-pressure, re-rolled every cycle
  always @(negedge clk) begin
    out_tready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still expected", cycles,
               pending_rows.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // zero acts as one, anything past the maximum saturates
  function automatic int unsigned tiles_eff(input logic [CFG_SIZE_W-1:0] v,
                                            input int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return v;
  endfunction

  // decode one accepted row, queue its result and step the sweep counters
  task automatic predict_row(input logic [31:0] d);
    int unsigned w, h, tstride, col, row, rit, sh;
    logic [7:0]  p0, p1, p2, p3;
    row_result_t r;
    w       = tiles_eff(m_width, MAX_TILES_WIDE);
    h       = tiles_eff(m_height, MAX_TILES_HIGH);
    col     = m_col;
    row     = m_row;
    rit     = m_rit;
    p0      = d[7:0];
    p1      = d[15:8];
    // upper planes do not exist in two-plane mode
    p2      = m_two_plane ? 8'h00 : d[23:16];
    p3      = m_two_plane ? 8'h00 : d[31:24];
    tstride = m_two_plane ? 16 : 32;
    r.offset = OFFSET_W'((row * 8 + rit) * (8 * w) + col * 8);
    r.addr   = ADDR_W'(m_base + m_stride * row + tstride * col + 2 * rit);
    for (int l = 0; l < NUM_PIX; l++) begin
      sh = 7 - l;
      r.pix[l] = {p3[sh], p2[sh], p1[sh], p0[sh]};
    end
    // counters beyond a shrunken size still count as the final position
    r.last = (col + 1 >= w) && (row + 1 >= h) && (rit == 7);
    pending_rows.push_back(r);
    m_rit = m_rit + 3'd1;
    if (m_rit == 3'd0) begin
      col = col + 1;
      if (col >= w) begin
        col = 0;
        row = row + 1;
        if (row >= h) row = 0;
      end
      m_col = col[5:0];
      m_row = row[5:0];
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("row %0d %s mismatch: expected %h, got %h", rows_checked, name,
                 want_v, got_v);
    end
  endtask

  task automatic check_row();
    row_result_t want;
    if (pending_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
      return;
    end
    want = pending_rows.pop_front();
    rows_checked++;
    check_field("pixel_offset", want.offset, out_tdata[17:0]);
    check_field("source_address", want.addr, out_tdata[49:18]);
    for (int l = 0; l < NUM_PIX; l++)
      check_field($sformatf("pixel %0d", l), want.pix[l], out_tdata[50 + 4 * l +: 4]);
    check_field("last_row", want.last, out_tlast);
  endtask

  // all handshakes observed at the rising edge; results are checked before
  // the same edge's input is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      m_base      = '0;
      m_stride    = ROW_STRIDE_RST;
      m_width     = 7'd1;
      m_height    = 7'd1;
      m_two_plane = 1'b0;
      m_col       = '0;
      m_row       = '0;
      m_rit       = '0;
    end else begin
      if (out_tvalid && out_tready) check_row();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_ADDRESS:   m_base      = cfg_data;
          REG_ROW_STRIDE:     m_stride    = cfg_data[STRIDE_W-1:0];
          REG_WIDTH_TILES:    m_width     = cfg_data[CFG_SIZE_W-1:0];
          REG_HEIGHT_TILES:   m_height    = cfg_data[CFG_SIZE_W-1:0];
          REG_TWO_PLANE_MODE: m_two_plane = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_row(in_tdata);
    end
  end

  // called and returning at a falling edge
  task automatic send_row(input logic [31:0] d);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    rows_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every queued row, then let the pipeline empty
  task automatic settle();
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'd0;
    if (roll < 20) return $urandom_range(65, 127);
    if (roll < 25) return 32'd64;
    if (roll < 30) return $urandom;
    return $urandom_range(1, 4);
  endfunction

  // reset defaults: one four-plane tile, so the ninth row wraps the sweep
  task automatic test_default_sweep();
    send_row(32'h0000_0000);
    send_row(32'hFFFF_FFFF);
    send_row(32'h0000_00FF);
    send_row(32'h0000_FF00);
    send_row(32'h00FF_0000);
    send_row(32'hFF00_0000);
    send_row(32'h8040_2010);
    send_row(32'h0102_0408);
    send_row($urandom);
  endtask

  // register extremes, zero sizes, address wrap, ignored upper planes
  task automatic test_register_extremes();
    settle();
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
    write_reg(REG_ROW_STRIDE, 32'h0000_FFFF);
    write_reg(REG_WIDTH_TILES, 32'd0);
    write_reg(REG_HEIGHT_TILES, 32'd0);
    write_reg(REG_TWO_PLANE_MODE, 32'd1);
    send_row(32'hFFFF_0000);
    send_row(32'hA5C3_3C5A);
    send_row(32'hFFFF_FFFF);
    settle();
    write_reg(REG_BASE_ADDRESS, 32'd0);
    write_reg(REG_ROW_STRIDE, 32'd0);
    write_reg(REG_TWO_PLANE_MODE, 32'd0);
    write_reg(REG_WIDTH_TILES, 32'd64);
    write_reg(REG_HEIGHT_TILES, 32'd64);
    send_row(32'hFFFF_0000);
    send_row(32'h0F0F_F0F0);
    send_row($urandom);
  endtask

  // sizes past the maximum saturate, upper data bits are masked off
  task automatic test_oversize();
    settle();
    write_reg(REG_WIDTH_TILES, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT_TILES, 32'd65);
    repeat (3) send_row($urandom);
  endtask

  task automatic test_spare_index();
    settle();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(i[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
    repeat (3) send_row($urandom);
  endtask

  // walk the counters well up into a tall and then a wide sprite, then
  // shrink the sprite under the running sweep
  task automatic test_deep_counters();
    settle();
    write_reg(REG_WIDTH_TILES, 32'd1);
    write_reg(REG_HEIGHT_TILES, 32'd64);
    write_reg(REG_BASE_ADDRESS, $urandom);
    write_reg(REG_ROW_STRIDE, $urandom);
    idle_on = 1'b0;  // long stretch at full rate on both sides
    while (m_row != 6'd15) send_row($urandom);
    idle_on = 1'b1;
    settle();
    write_reg(REG_WIDTH_TILES, 32'd64);
    while (m_col != 6'd7) send_row($urandom);
    repeat (4) send_row($urandom);
    settle();
    write_reg(REG_WIDTH_TILES, $urandom_range(1, 3));
    write_reg(REG_HEIGHT_TILES, 32'd2);
    repeat (20) send_row($urandom);
  endtask

  // random register settings between random-length runs; runs stop mid-tile
  // so new sizes often land under counters that are already past them
  task automatic test_random_phases();
    int unsigned n_rows;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      idle_on = (ph != NUM_PHASES / 2);
      if (ph == 0 || $urandom_range(99) < 60)
        write_reg(REG_BASE_ADDRESS,
                  ($urandom_range(9) == 0) ? ~32'($urandom_range(255)) : $urandom);
      if (ph == 0 || $urandom_range(99) < 60)
        write_reg(REG_ROW_STRIDE, $urandom);
      if (ph == 0 || $urandom_range(99) < 60)
        write_reg(REG_WIDTH_TILES, pick_size());
      if (ph == 0 || $urandom_range(99) < 60)
        write_reg(REG_HEIGHT_TILES, pick_size());
      if (ph == 0 || $urandom_range(99) < 60)
        write_reg(REG_TWO_PLANE_MODE, $urandom);
      n_rows = $urandom_range(20, 45);
      repeat (n_rows) send_row($urandom);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_default_sweep();
    test_register_extremes();
    test_oversize();
    test_spare_index();
    test_deep_counters();
    test_random_phases();
    settle();
    $display("%0d rows sent, %0d decoded rows checked, %0d register writes",
             rows_sent, rows_checked, cfg_writes);
    $display("covered default, zero, oversize and shrunken sprites in both plane modes");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d rows never arrived", mismatches, pending_rows.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: planar_tile_to_chunky_pixels_core.f
+incdir+sv
sv/ptcp_pkg.sv
sv/ptcp_cfg.sv
sv/ptcp_seq.sv
sv/ptcp_dec.sv
sv/planar_tile_to_chunky_pixels_core.sv
tb/planar_tile_to_chunky_pixels_core_tb.sv
